[hw/rtl/qphs_pkg.sv]
// ----------------------------------------------------------------------------
// qphs_pkg
// Shared types and codes for the quadratic probing hash set: request and
// reply codes, slot states and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package qphs_pkg;

    localparam int ACT_W     = 2;
    localparam int KEY_W     = 31;
    localparam int STAT_W    = 3;
    localparam int OUT_IDX_W = 4;
    localparam int MOD_CNT_W = 2;

    localparam logic [MOD_CNT_W-1:0] MOD_LAST = 2'd2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd5;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_REMOVED  = 2'd2;

    typedef logic [1:0] slot_sel_t;
    localparam slot_sel_t SEL_ZERO  = 2'd0;
    localparam slot_sel_t SEL_PROBE = 2'd1;
    localparam slot_sel_t SEL_TOMB  = 2'd2;

    typedef struct packed {
        logic              clear_step;
        logic              load;
        logic              mod_step;
        logic              probe_init;
        logic              probe_next;
        logic              note_tomb;
        logic              mem_rd;
        logic              mem_wr;
        logic [1:0]        wr_state;
        slot_sel_t         sel;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
    } qphs_cmd_t;

    typedef struct packed {
        logic             clear_done;
        logic             mod_done;
        logic             last_probe;
        logic [ACT_W-1:0] action;
        logic             slot_free;
        logic             slot_match;
        logic             slot_tomb;
        logic             have_tomb;
        logic             res_busy;
    } qphs_stat_t;

endpackage

`default_nettype wire

[hw/rtl/quadratic_probe_hash_set.sv]
// ----------------------------------------------------------------------------
// quadratic_probe_hash_set
// Open addressing set of 31-bit keys with quadratic probing: insert, remove
// and search, one reply beat per request beat.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (lowest bit up)
//  s_*       in   action[1:0], key[32:2], zero pad to 40 bits
//  m_*       out  status[2:0], slot_index[6:3], zero pad to 8 bits
//
//  a request finds the home slot remainder (reciprocal multiply, subtract,
//  correct) and then probes the table, each probe a slot memory read and then
//  a check, at most TABLE_SLOTS probes; the unused action code replies
//  without probing
//  after reset a clear pass marks every slot free with s_tready low
//  a reply waits in the output register while the next request is taken;
//  a request reaching its reply holds until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_set
    import qphs_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // action[1:0], key[32:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status[2:0], slot_index[6:3]
);

    qphs_cmd_t            cmd;
    qphs_stat_t           stat;
    logic                 in_ready;
    logic [STAT_W-1:0]    res_status;
    logic [OUT_IDX_W-1:0] res_slot;

    assign s_tready = in_ready;

    qphs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    qphs_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tdata[ACT_W-1:0]),
        .in_key     (s_tdata[ACT_W +: KEY_W]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_slot   (res_slot)
    );

    assign m_tdata = {1'b0, res_slot, res_status};

endmodule

`default_nettype wire

[hw/rtl/qphs_ctrl.sv]
// ----------------------------------------------------------------------------
// qphs_ctrl
// Request sequencer: clear pass, home slot remainder, probe read and check,
// insert/remove write-back and reply hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module qphs_ctrl
    import qphs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire qphs_stat_t stat,
    output qphs_cmd_t       cmd,
    output logic            in_ready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_REPLY = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_insert;
    logic       is_remove;
    logic       act_ok;

    assign is_insert = (stat.action == ACT_INSERT);
    assign is_remove = (stat.action == ACT_REMOVE);
    assign act_ok    = is_insert || is_remove || (stat.action == ACT_SEARCH);
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = act_ok ? S_READ : S_REPLY;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.res_busy)
                begin
                    priority if (stat.slot_match)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.sel      = SEL_PROBE;
                        if (is_insert)
                        begin
                            cmd.res_status = ST_PRESENT;
                        end
                        else if (is_remove)
                        begin
                            cmd.res_status = ST_REMOVED;
                            cmd.mem_wr     = 1'b1;
                            cmd.wr_state   = SLOT_REMOVED;
                        end
                        else
                        begin
                            cmd.res_status = ST_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                    else if (stat.slot_free)
                    begin
                        cmd.res_load = 1'b1;
                        if (is_insert)
                        begin
                            cmd.sel        = SEL_TOMB;
                            cmd.res_status = ST_INSERTED;
                            cmd.mem_wr     = 1'b1;
                            cmd.wr_state   = SLOT_OCCUPIED;
                        end
                        else
                        begin
                            cmd.sel        = SEL_ZERO;
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                    else if (stat.last_probe)
                    begin
                        cmd.res_load = 1'b1;
                        if (is_insert && (stat.have_tomb || stat.slot_tomb))
                        begin
                            cmd.sel        = SEL_TOMB;
                            cmd.res_status = ST_INSERTED;
                            cmd.mem_wr     = 1'b1;
                            cmd.wr_state   = SLOT_OCCUPIED;
                        end
                        else
                        begin
                            cmd.sel        = SEL_ZERO;
                            cmd.res_status = is_insert ? ST_FULL : ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.note_tomb  = stat.slot_tomb;
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_REPLY:
            begin
                if (!stat.res_busy)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.sel        = SEL_ZERO;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/qphs_datapath.sv]
// ----------------------------------------------------------------------------
// qphs_datapath
// Slot memory, home slot remainder by reciprocal multiply, incremental
// quadratic probe address, tombstone tracking and the reply register.
// ----------------------------------------------------------------------------
`default_nettype none

module qphs_datapath
    import qphs_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qphs_cmd_t            cmd,
    output qphs_stat_t                stat,
    input  wire logic [ACT_W-1:0]     in_action,
    input  wire logic [KEY_W-1:0]     in_key,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic [STAT_W-1:0]         res_status,
    output logic [OUT_IDX_W-1:0]      res_slot
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W-1:0] ODD_INIT = IDX_W'(1 % TABLE_SLOTS);
    localparam logic [IDX_W-1:0] TWO_MOD  = IDX_W'(2 % TABLE_SLOTS);
    localparam logic [KEY_W-1:0] RECIP    = KEY_W'((64'd1 << KEY_W) / TABLE_SLOTS);

    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SLOTS_X)
        begin
            s = s - SLOTS_X;
        end
        return s[IDX_W-1:0];
    endfunction

    logic [KEY_W+1:0]     mem [TABLE_SLOTS];
    logic [KEY_W+1:0]     rd_data_reg;

    logic [ACT_W-1:0]     action_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [2*KEY_W-1:0]   prod_reg;
    logic [IDX_W:0]       rem_est_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [IDX_W-1:0]     sq_reg;
    logic [IDX_W-1:0]     odd_reg;
    logic [IDX_W-1:0]     step_reg;
    logic                 have_tomb_reg;
    logic [IDX_W-1:0]     tomb_reg;
    logic                 res_valid_reg;
    logic [STAT_W-1:0]    res_status_reg;
    logic [OUT_IDX_W-1:0] res_slot_reg;

    logic [2*KEY_W-1:0]   prod_next;
    logic [2*IDX_W+1:0]   qn_lo;
    logic [IDX_W:0]       rem_est_next;
    logic [IDX_W:0]       rem_fix;
    logic [IDX_W-1:0]     probe_idx;
    logic [IDX_W-1:0]     tomb_idx;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W+3:0]     sel_wide;
    logic [1:0]           rd_state;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_W+1:0]     mem_wdata;

    // quotient estimate is low by at most one, so one subtract corrects it
    assign prod_next    = (2*KEY_W)'(key_reg) * (2*KEY_W)'(RECIP);
    assign qn_lo        = (2*IDX_W+2)'(prod_reg[KEY_W +: IDX_W+1]) * (2*IDX_W+2)'(SLOTS_X);
    assign rem_est_next = key_reg[IDX_W:0] - qn_lo[IDX_W:0];
    assign rem_fix      = (rem_est_reg >= SLOTS_X) ? (rem_est_reg - SLOTS_X) : rem_est_reg;

    assign probe_idx = mod_add(rem_reg, sq_reg);
    assign tomb_idx  = have_tomb_reg ? tomb_reg : probe_idx;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_PROBE: sel_idx = probe_idx;
            SEL_TOMB:  sel_idx = tomb_idx;
            default:   sel_idx = '0;
        endcase
    end

    assign sel_wide = {4'b0000, sel_idx};

    assign mem_we    = cmd.clear_step || cmd.mem_wr;
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : sel_idx;
    assign mem_wdata = cmd.clear_step ? {SLOT_FREE, {KEY_W{1'b0}}} : {cmd.wr_state, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[probe_idx];
        end
    end

    assign rd_state = rd_data_reg[KEY_W +: 2];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            mod_cnt_reg   <= '0;
            step_reg      <= '0;
            have_tomb_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.probe_init)
            begin
                step_reg      <= '0;
                have_tomb_reg <= 1'b0;
            end
            else
            begin
                if (cmd.probe_next)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (cmd.note_tomb)
                begin
                    have_tomb_reg <= 1'b1;
                end
            end
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            key_reg    <= in_key;
        end
        // multiply, subtract, correct: one stage per cycle
        if (cmd.mod_step)
        begin
            prod_reg    <= prod_next;
            rem_est_reg <= rem_est_next;
            rem_reg     <= rem_fix[IDX_W-1:0];
        end
        if (cmd.probe_init)
        begin
            sq_reg  <= '0;
            odd_reg <= ODD_INIT;
        end
        else if (cmd.probe_next)
        begin
            sq_reg  <= mod_add(sq_reg, odd_reg);
            odd_reg <= mod_add(odd_reg, TWO_MOD);
        end
        if (cmd.note_tomb && !have_tomb_reg)
        begin
            tomb_reg <= probe_idx;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= sel_wide[OUT_IDX_W-1:0];
        end
    end

    assign stat.clear_done = (clr_cnt_reg == LAST_IDX);
    assign stat.mod_done   = (mod_cnt_reg == MOD_LAST);
    assign stat.last_probe = (step_reg == LAST_IDX);
    assign stat.action     = action_reg;
    assign stat.slot_free  = (rd_state == SLOT_FREE);
    assign stat.slot_match = (rd_state == SLOT_OCCUPIED) && (rd_data_reg[KEY_W-1:0] == key_reg);
    assign stat.slot_tomb  = (rd_state != SLOT_FREE) && (rd_state != SLOT_OCCUPIED);
    assign stat.have_tomb  = have_tomb_reg;
    assign stat.res_busy   = res_valid_reg && !res_ready;

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_slot   = res_slot_reg;

endmodule

`default_nettype wire
